/* rtl/core/rrts_pkg.sv */
// Shared types, constants and field layout of the round-robin thread scheduler.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rrts_pkg;

    // Thread slot table size
    localparam int MAX_THREADS = 16;
    localparam int SLOT_W      = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);

    // Field widths
    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int OSLOT_W = 4;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [ID_W-1:0]    id_t;
    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [OSLOT_W-1:0] oslot_t;

    // Event modes
    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_YIELD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXIT   = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd2;

    // Input stream layout
    localparam int IN_DATA_W = 32;
    localparam int IN_USER_W = 2;

    // Result stream layout, lowest bit first
    localparam int O_STATUS_LSB = 0;
    localparam int O_SWITCHED   = 2;
    localparam int O_RSLOT_LSB  = 3;
    localparam int O_RID_LSB    = 7;
    localparam int O_CSLOT_LSB  = 23;
    localparam int O_TOTAL_LSB  = 27;
    localparam int O_BURST_LSB  = 59;
    localparam int O_FIELDS_W   = 91;
    localparam int O_DATA_W     = ((O_FIELDS_W + 7) / 8) * 8;

    // Controller to datapath commands
    typedef struct packed {
        logic              latch;
        logic              status_we;
        logic [STAT_W-1:0] status_code;
        logic              create;
        logic              do_switch;
        logic              load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              fifo_empty;
        logic              free_found;
        logic              soc;
        logic              out_busy;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/core/round_robin_thread_scheduler.sv */
// Top level of the round-robin thread scheduler: stream ports, controller, datapath.
// Depends on rrts_pkg, rrts_ctrl and rrts_dp.
`default_nettype none

// Scheduling events (create, yield, exit) arrive one at a time on the slave stream and
// each gives one result on the master stream. An event takes its turn through a short
// sequence of table accesses, and the next event can be taken in the cycle after the
// result is loaded. A rejected or ignored event goes from decode to the result, a create
// adds a create step, a yield or exit a switch and an id read, a switching create both
// with a read between; this comes from the single write port and registered read port
// of each slot table and of the ready queue. A finished result waits in the output
// register without holding up the next decode. No clearing pass is needed after reset.
module round_robin_thread_scheduler (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_wdata,   // switch_on_create
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rrts_pkg::IN_DATA_W-1:0] s_tdata,     // now_time[31:0]
    input  wire logic [rrts_pkg::IN_USER_W-1:0] s_tuser,     // mode[1:0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status[1:0], switched[2], running_slot[6:3], running_id[22:7], created_slot[26:23],
    // left_total_time[58:27], left_last_burst[90:59], zero[95:91]
    output logic [rrts_pkg::O_DATA_W-1:0]       m_tdata
);

    rrts_pkg::cmd_t  cmd;
    rrts_pkg::stat_t stat;

    rrts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrts_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_time   (s_tdata),
        .in_mode   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

/* rtl/core/rrts_rdyq.sv */
// Ready queue of the scheduler: a circular FIFO of slot indexes.
// Depends on rrts_pkg for the slot and count types.
`default_nettype none

module rrts_rdyq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire rrts_pkg::slot_t push_slot,
    input  wire logic          pop,
    output rrts_pkg::slot_t    head_slot,
    output logic               empty,
    output logic               full
);

    rrts_pkg::slot_t mem [rrts_pkg::MAX_THREADS];
    rrts_pkg::slot_t head_reg, head_next;
    rrts_pkg::slot_t tail_reg, tail_next;
    rrts_pkg::cnt_t  count_reg, count_next;
    rrts_pkg::slot_t rd_reg;
    logic            push_ok;

    // Advance a pointer with wrap at the table size
    function automatic rrts_pkg::slot_t ptr_inc(input rrts_pkg::slot_t p);
        rrts_pkg::slot_t r;
        if (p == rrts_pkg::slot_t'(rrts_pkg::MAX_THREADS - 1))
            r = '0;
        else
            r = p + rrts_pkg::slot_t'(1);
        return r;
    endfunction

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == rrts_pkg::cnt_t'(rrts_pkg::MAX_THREADS));
    assign push_ok   = push && (!full || pop);
    assign head_slot = rd_reg;

    // Update pointers and fill count
    always_comb
    begin
        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        tail_next  = push_ok ? ptr_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (push_ok && !pop)
            count_next = count_reg + rrts_pkg::cnt_t'(1);
        else if (!push_ok && pop)
            count_next = count_reg - rrts_pkg::cnt_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Write at the tail, read the head every cycle
    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem[tail_reg] <= push_slot;
        rd_reg <= mem[head_reg];
    end

endmodule

`default_nettype wire

/* rtl/core/rrts_dp.sv */
// Datapath of the scheduler: slot tables, free mask, burst accounting, result register.
// Depends on rrts_pkg and instantiates the ready queue rrts_rdyq.
`default_nettype none

module rrts_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_wdata,
    input  wire logic [rrts_pkg::IN_DATA_W-1:0] in_time,
    input  wire logic [rrts_pkg::MODE_W-1:0]    in_mode,
    input  wire rrts_pkg::cmd_t                 cmd,
    output rrts_pkg::stat_t                     stat,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [rrts_pkg::O_DATA_W-1:0]       out_data
);

    localparam int N = rrts_pkg::MAX_THREADS;

    // Configuration and latched event
    logic                        soc_reg;
    logic [rrts_pkg::MODE_W-1:0] mode_reg;
    rrts_pkg::time_t             now_reg;

    // Scheduler state
    rrts_pkg::slot_t cur_reg, cur_next;
    rrts_pkg::id_t   next_id_reg;
    logic [N-1:0]    free_reg, free_next;
    logic [N-1:0]    id_vld_reg, bst_vld_reg, tot_vld_reg;

    // Slot tables and their registered read ports
    rrts_pkg::id_t   id_mem  [N];
    rrts_pkg::time_t bst_mem [N];
    rrts_pkg::time_t tot_mem [N];
    rrts_pkg::id_t   id_rd_reg;
    rrts_pkg::time_t bst_rd_reg, tot_rd_reg;
    logic            id_ok_reg, bst_ok_reg, tot_ok_reg;

    // Result being built and output register
    logic [rrts_pkg::STAT_W-1:0] res_status_reg;
    logic                        res_switched_reg;
    rrts_pkg::slot_t             res_cslot_reg;
    rrts_pkg::time_t             res_total_reg, res_burst_reg;
    logic [rrts_pkg::STAT_W-1:0] out_status_reg;
    logic                        out_switched_reg;
    rrts_pkg::oslot_t            out_rslot_reg, out_cslot_reg;
    rrts_pkg::id_t               out_rid_reg;
    rrts_pkg::time_t             out_total_reg, out_burst_reg;
    logic                        out_valid_reg;

    // Combinational helpers
    rrts_pkg::slot_t        fs;
    logic                   found;
    rrts_pkg::slot_t        q_head, q_push_slot;
    logic                   q_push, q_empty, q_full;
    logic                   exiting;
    rrts_pkg::time_t        bst_eff, tot_eff, burst, sum;
    logic [rrts_pkg::TIME_W:0] sum_w;
    rrts_pkg::id_t          rid_eff;
    logic                   bst_we, tot_we;
    rrts_pkg::slot_t        bst_wa, tot_wa;
    rrts_pkg::time_t        bst_wd, tot_wd;

    // Lowest set bit of the free mask
    function automatic rrts_pkg::slot_t first_free(input logic [N-1:0] v);
        rrts_pkg::slot_t r;
        r = '0;
        for (int i = N - 1; i >= 0; i--)
            if (v[i])
                r = rrts_pkg::slot_t'(i);
        return r;
    endfunction

    assign fs    = first_free(free_reg);
    assign found = |free_reg;

    rrts_rdyq u_rdyq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_slot (q_push_slot),
        .pop       (cmd.do_switch),
        .head_slot (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Requeue the running thread unless it exits; the main thread never exits
    assign exiting     = (mode_reg == rrts_pkg::MODE_EXIT) && (cur_reg != '0);
    assign q_push      = cmd.create || (cmd.do_switch && !exiting);
    assign q_push_slot = cmd.create ? fs : cur_reg;

    // Entries never written read as zero
    assign bst_eff = bst_ok_reg ? bst_rd_reg : '0;
    assign tot_eff = tot_ok_reg ? tot_rd_reg : '0;
    assign rid_eff = id_ok_reg ? id_rd_reg : '0;

    // Burst length and saturating total
    assign burst = now_reg - bst_eff;
    assign sum_w = {1'b0, tot_eff} + {1'b0, burst};
    assign sum   = sum_w[rrts_pkg::TIME_W] ? '1 : sum_w[rrts_pkg::TIME_W-1:0];

    // Table write ports: create clears the new slot, switch does the accounting
    assign bst_we = cmd.create || cmd.do_switch;
    assign bst_wa = cmd.create ? fs : q_head;
    assign bst_wd = cmd.create ? '0 : now_reg;
    assign tot_we = cmd.create || cmd.do_switch;
    assign tot_wa = cmd.create ? fs : cur_reg;
    assign tot_wd = cmd.create ? '0 : sum;

    // Next free mask and running slot
    always_comb
    begin
        free_next = free_reg;
        if (cmd.create && !q_full)
            free_next[fs] = 1'b0;
        if (cmd.do_switch && exiting)
            free_next[cur_reg] = 1'b1;
        cur_next = cmd.do_switch ? q_head : cur_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soc_reg       <= 1'b0;
            cur_reg       <= '0;
            next_id_reg   <= rrts_pkg::id_t'(1);
            free_reg      <= {{(N-1){1'b1}}, 1'b0};
            id_vld_reg    <= '0;
            bst_vld_reg   <= '0;
            tot_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                soc_reg <= cfg_wdata;
            cur_reg  <= cur_next;
            free_reg <= free_next;
            if (cmd.create)
            begin
                next_id_reg    <= next_id_reg + rrts_pkg::id_t'(1);
                id_vld_reg[fs] <= 1'b1;
            end
            if (bst_we)
                bst_vld_reg[bst_wa] <= 1'b1;
            if (tot_we)
                tot_vld_reg[tot_wa] <= 1'b1;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Slot tables: one write each, read at the running slot every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.create)
            id_mem[fs] <= next_id_reg;
        if (bst_we)
            bst_mem[bst_wa] <= bst_wd;
        if (tot_we)
            tot_mem[tot_wa] <= tot_wd;
        id_rd_reg  <= id_mem[cur_reg];
        bst_rd_reg <= bst_mem[cur_reg];
        tot_rd_reg <= tot_mem[cur_reg];
        id_ok_reg  <= id_vld_reg[cur_reg];
        bst_ok_reg <= bst_vld_reg[cur_reg];
        tot_ok_reg <= tot_vld_reg[cur_reg];
    end

    // Latch the event and build the result
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg         <= in_mode;
            now_reg          <= in_time;
            res_status_reg   <= rrts_pkg::STAT_DONE;
            res_switched_reg <= 1'b0;
            res_cslot_reg    <= '0;
            res_total_reg    <= '0;
            res_burst_reg    <= '0;
        end
        if (cmd.status_we)
            res_status_reg <= cmd.status_code;
        if (cmd.create)
            res_cslot_reg <= fs;
        if (cmd.do_switch)
        begin
            res_switched_reg <= 1'b1;
            res_total_reg    <= sum;
            res_burst_reg    <= burst;
        end
        if (cmd.load_out)
        begin
            out_status_reg   <= res_status_reg;
            out_switched_reg <= res_switched_reg;
            out_rslot_reg    <= rrts_pkg::oslot_t'(cur_reg);
            out_rid_reg      <= rid_eff;
            out_cslot_reg    <= rrts_pkg::oslot_t'(res_cslot_reg);
            out_total_reg    <= res_total_reg;
            out_burst_reg    <= res_burst_reg;
        end
    end

    assign stat.mode       = mode_reg;
    assign stat.fifo_empty = q_empty;
    assign stat.free_found = found;
    assign stat.soc        = soc_reg;
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = rrts_pkg::O_DATA_W'({out_burst_reg, out_total_reg, out_cslot_reg,
                                            out_rid_reg, out_rslot_reg, out_switched_reg,
                                            out_status_reg});

endmodule

`default_nettype wire

/* rtl/core/rrts_ctrl.sv */
// Controller of the scheduler: sequences one event through the datapath.
// Depends on rrts_pkg for the command and status structs and the mode codes.
`default_nettype none

module rrts_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rrts_pkg::stat_t stat,
    output rrts_pkg::cmd_t       cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DECODE  = 7'b0000010,
        ST_CREATE  = 7'b0000100,
        ST_SW_READ = 7'b0001000,
        ST_SWITCH  = 7'b0010000,
        ST_ID_READ = 7'b0100000,
        ST_RESULT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.mode)
                    rrts_pkg::MODE_CREATE:
                    begin
                        if (stat.free_found)
                            state_next = ST_CREATE;
                        else
                        begin
                            cmd.status_we   = 1'b1;
                            cmd.status_code = rrts_pkg::STAT_NOFREE;
                            state_next      = ST_RESULT;
                        end
                    end
                    rrts_pkg::MODE_YIELD, rrts_pkg::MODE_EXIT:
                    begin
                        if (stat.fifo_empty)
                        begin
                            cmd.status_we   = 1'b1;
                            cmd.status_code = rrts_pkg::STAT_EMPTY;
                            state_next      = ST_RESULT;
                        end
                        else
                            state_next = ST_SWITCH;
                    end
                    default:
                        state_next = ST_RESULT;
                endcase
            end
            ST_CREATE:
            begin
                cmd.create = 1'b1;
                state_next = stat.soc ? ST_SW_READ : ST_RESULT;
            end
            ST_SW_READ:
                state_next = ST_SWITCH;
            ST_SWITCH:
            begin
                cmd.do_switch = 1'b1;
                state_next    = ST_ID_READ;
            end
            ST_ID_READ:
                state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* rtl/core/rrts_chk.sv */
// Port-level checker for the round-robin thread scheduler, bound to the top level.
// Depends on rrts_pkg for the result field layout and status codes.
`default_nettype none

module rrts_chk (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [rrts_pkg::O_DATA_W-1:0]  m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Take no new event right after accepting one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("event accepted while another is in progress");

    // Report burst figures only on a switch
    a_left_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[rrts_pkg::O_SWITCHED]
        |-> m_tdata[rrts_pkg::O_FIELDS_W-1:rrts_pkg::O_TOTAL_LSB] == '0)
        else $error("burst figures set without a switch");

    // Switch only on a successful event
    a_switch_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[rrts_pkg::O_SWITCHED]
        |-> m_tdata[rrts_pkg::O_STATUS_LSB+1:rrts_pkg::O_STATUS_LSB] == rrts_pkg::STAT_DONE)
        else $error("switch reported with a failure status");

    // Claim a slot only on a successful create
    a_created_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[rrts_pkg::O_CSLOT_LSB+3:rrts_pkg::O_CSLOT_LSB] != '0)
        |-> m_tdata[rrts_pkg::O_STATUS_LSB+1:rrts_pkg::O_STATUS_LSB] == rrts_pkg::STAT_DONE)
        else $error("created slot reported with a failure status");

endmodule

bind round_robin_thread_scheduler rrts_chk u_rrts_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
